FILE: sv/tsd_pkg.sv
// Shared constants, microcode word layout and microcode ROM of the degree-input sine block.
package tsd_pkg;

    localparam int MAX_TERM_PAIRS = 32;
    localparam int RECIP_DEPTH    = 2 * MAX_TERM_PAIRS;
    localparam int UPC_W          = 6;
    localparam int RC_W           = 7;

    localparam logic [5:0]  TERM_PAIRS_RESET = 6'd8;
    localparam logic [30:0] DEG_TO_RAD_Q36   = 31'd1199381129;
    localparam logic [34:0] TWO_PI_Q32       = 35'h6_487E_D511;
    localparam logic [63:0] ONE_Q32          = 64'h1_0000_0000;

    // floor(2^16 / (2*pi)): the radian magnitude shifted down by 24 bits times this,
    // shifted down by another 24 bits, never overestimates the number of whole turns
    // and falls short by at most one.
    localparam logic [13:0] TURN_RECIP_Q24   = 14'd10430;

    // Reciprocals floor(2^32 / (2n(2n+1))) for n = 1 .. RECIP_DEPTH.
    localparam logic [31:0] RECIP_ROM [RECIP_DEPTH] = '{
        32'(ONE_Q32 / 64'd6),     32'(ONE_Q32 / 64'd20),    32'(ONE_Q32 / 64'd42),
        32'(ONE_Q32 / 64'd72),    32'(ONE_Q32 / 64'd110),   32'(ONE_Q32 / 64'd156),
        32'(ONE_Q32 / 64'd210),   32'(ONE_Q32 / 64'd272),   32'(ONE_Q32 / 64'd342),
        32'(ONE_Q32 / 64'd420),   32'(ONE_Q32 / 64'd506),   32'(ONE_Q32 / 64'd600),
        32'(ONE_Q32 / 64'd702),   32'(ONE_Q32 / 64'd812),   32'(ONE_Q32 / 64'd930),
        32'(ONE_Q32 / 64'd1056),  32'(ONE_Q32 / 64'd1190),  32'(ONE_Q32 / 64'd1332),
        32'(ONE_Q32 / 64'd1482),  32'(ONE_Q32 / 64'd1640),  32'(ONE_Q32 / 64'd1806),
        32'(ONE_Q32 / 64'd1980),  32'(ONE_Q32 / 64'd2162),  32'(ONE_Q32 / 64'd2352),
        32'(ONE_Q32 / 64'd2550),  32'(ONE_Q32 / 64'd2756),  32'(ONE_Q32 / 64'd2970),
        32'(ONE_Q32 / 64'd3192),  32'(ONE_Q32 / 64'd3422),  32'(ONE_Q32 / 64'd3660),
        32'(ONE_Q32 / 64'd3906),  32'(ONE_Q32 / 64'd4160),  32'(ONE_Q32 / 64'd4422),
        32'(ONE_Q32 / 64'd4692),  32'(ONE_Q32 / 64'd4970),  32'(ONE_Q32 / 64'd5256),
        32'(ONE_Q32 / 64'd5550),  32'(ONE_Q32 / 64'd5852),  32'(ONE_Q32 / 64'd6162),
        32'(ONE_Q32 / 64'd6480),  32'(ONE_Q32 / 64'd6806),  32'(ONE_Q32 / 64'd7140),
        32'(ONE_Q32 / 64'd7482),  32'(ONE_Q32 / 64'd7832),  32'(ONE_Q32 / 64'd8190),
        32'(ONE_Q32 / 64'd8556),  32'(ONE_Q32 / 64'd8930),  32'(ONE_Q32 / 64'd9312),
        32'(ONE_Q32 / 64'd9702),  32'(ONE_Q32 / 64'd10100), 32'(ONE_Q32 / 64'd10506),
        32'(ONE_Q32 / 64'd10920), 32'(ONE_Q32 / 64'd11342), 32'(ONE_Q32 / 64'd11772),
        32'(ONE_Q32 / 64'd12210), 32'(ONE_Q32 / 64'd12656), 32'(ONE_Q32 / 64'd13110),
        32'(ONE_Q32 / 64'd13572), 32'(ONE_Q32 / 64'd14042), 32'(ONE_Q32 / 64'd14520),
        32'(ONE_Q32 / 64'd15006), 32'(ONE_Q32 / 64'd15500), 32'(ONE_Q32 / 64'd16002),
        32'(ONE_Q32 / 64'd16512)
    };

    typedef enum logic [3:0] {
        A_NOP,
        A_RAD,
        A_DIV,
        A_FIX,
        A_WX2,
        A_ADD,
        A_WP,
        A_SUB,
        A_NEWT,
        A_RND,
        A_OUT
    } act_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ALWAYS,
        J_DONE
    } jcond_t;

    typedef struct packed {
        act_t             act;
        logic             mul;
        logic             a_hi;
        logic             b_hi;
        logic             clr;
        jcond_t           jc;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] UPC_FIX = 6'd4;
    localparam logic [UPC_W-1:0] UPC_CHK = 6'd11;
    localparam logic [UPC_W-1:0] UPC_RND = 6'd33;
    localparam logic [UPC_W-1:0] UPC_OUT = 6'd34;

    function automatic uword_t uw_act(act_t act, jcond_t jc, logic [UPC_W-1:0] target);
        uword_t w;
        w        = '0;
        w.act    = act;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t uw_mul(logic a_hi, logic b_hi, logic clr);
        uword_t w;
        w      = '0;
        w.act  = A_NOP;
        w.jc   = J_NEXT;
        w.mul  = 1'b1;
        w.a_hi = a_hi;
        w.b_hi = b_hi;
        w.clr  = clr;
        return w;
    endfunction

    // Each multiply issues one 32x32 partial product per step; the partial product is
    // registered before it is added into the sum, hence the idle step after each.
    function automatic uword_t ucode_rom(logic [UPC_W-1:0] upc);
        uword_t w;
        unique case (upc)
            6'd0:  w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd1:  w = uw_act(A_NOP, J_NEXT, '0);
            6'd2:  w = uw_act(A_RAD, J_NEXT, '0);
            6'd3:  w = uw_act(A_DIV, J_NEXT, '0);
            6'd4:  w = uw_act(A_FIX, J_NEXT, '0);
            6'd5:  w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd6:  w = uw_mul(1'b0, 1'b1, 1'b0);
            6'd7:  w = uw_mul(1'b1, 1'b0, 1'b0);
            6'd8:  w = uw_mul(1'b1, 1'b1, 1'b0);
            6'd9:  w = uw_act(A_NOP, J_NEXT, '0);
            6'd10: w = uw_act(A_WX2, J_NEXT, '0);
            6'd11: w = uw_act(A_NOP, J_DONE, UPC_RND);
            6'd12: w = uw_act(A_ADD, J_NEXT, '0);
            6'd13: w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd14: w = uw_mul(1'b0, 1'b1, 1'b0);
            6'd15: w = uw_mul(1'b1, 1'b0, 1'b0);
            6'd16: w = uw_mul(1'b1, 1'b1, 1'b0);
            6'd17: w = uw_act(A_NOP, J_NEXT, '0);
            6'd18: w = uw_act(A_WP, J_NEXT, '0);
            6'd19: w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd20: w = uw_mul(1'b1, 1'b0, 1'b0);
            6'd21: w = uw_act(A_NOP, J_NEXT, '0);
            6'd22: w = uw_act(A_SUB, J_NEXT, '0);
            6'd23: w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd24: w = uw_mul(1'b0, 1'b1, 1'b0);
            6'd25: w = uw_mul(1'b1, 1'b0, 1'b0);
            6'd26: w = uw_mul(1'b1, 1'b1, 1'b0);
            6'd27: w = uw_act(A_NOP, J_NEXT, '0);
            6'd28: w = uw_act(A_WP, J_NEXT, '0);
            6'd29: w = uw_mul(1'b0, 1'b0, 1'b1);
            6'd30: w = uw_mul(1'b1, 1'b0, 1'b0);
            6'd31: w = uw_act(A_NOP, J_NEXT, '0);
            6'd32: w = uw_act(A_NEWT, J_ALWAYS, UPC_CHK);
            6'd33: w = uw_act(A_RND, J_NEXT, '0);
            6'd34: w = uw_act(A_OUT, J_NEXT, '0);
            default: w = uw_act(A_NOP, J_NEXT, '0);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/taylor_sine_degrees.sv
// Top level: microcoded Taylor-series sine of an angle given in degrees.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tdata[31:0] angle_degrees (signed Q16.16)
//  m_       | out       | tdata[31:0] sine_value (signed Q8.24); tuser[0] saturated
//  cfg_     | in        | data[5:0] term_pairs
//
// One angle at a time: the sequencer runs term_pairs series pairs, clamped to 32,
// on the shared 32x32 multiplier, where each series term costs six partial products
// plus write-back steps.
// Reset is synchronous and active low; term_pairs returns to 8.
// A new angle is taken while a finished result still waits; the sequencer holds
// at its output step only if the previous result has not been taken yet.
module taylor_sine_degrees
    import tsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] angle_degrees
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [31:0] m_tdata,   // [31:0] sine_value
    output logic [0:0]         m_tuser,   // [0] saturated
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);

    // Control state.
    logic             busy_reg, busy_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [5:0]       term_pairs_reg, term_pairs_next;
    logic             pp_vld_reg, pp_vld_next;

    // Datapath.
    logic               neg_reg, neg_next;
    logic [47:0]        opa_reg, opa_next;
    logic [47:0]        opb_reg, opb_next;
    logic [63:0]        pp_reg, pp_next;
    logic [1:0]         pp_sh_reg, pp_sh_next;
    logic               pp_clr_reg, pp_clr_next;
    logic [79:0]        acc_reg, acc_next;
    logic [42:0]        rad_reg, rad_next;
    logic               rad_nz_reg, rad_nz_next;
    logic [6:0]         quo_reg, quo_next;
    logic [47:0]        x2_reg, x2_next;
    logic [47:0]        term_reg, term_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [RC_W-1:0]    rc_reg, rc_next;
    logic [39:0]        smag_reg, smag_next;
    logic               fneg_reg, fneg_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_sat_reg, out_sat_next;

    uword_t      uw;
    logic        s_xfer;
    logic        out_free;
    logic        step;
    logic [31:0] ang_u;
    logic [31:0] ang_mag;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [79:0] pp_ext;
    logic [47:0] res;
    logic [62:0] rad_rnd;
    logic [32:0] turn_est;
    logic [42:0] turn_sub;
    logic [42:0] rad_red;
    logic [34:0] x_fix;
    logic [5:0]  pairs;
    logic        done;
    logic [47:0] sum_abs;
    logic [47:0] sum_rnd;

    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = $signed(out_data_reg);
    assign m_tuser   = out_sat_reg;

    always_comb begin
        uw       = ucode_rom(upc_reg);
        s_xfer   = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;
        step     = busy_reg && !((uw.act == A_OUT) && !out_free);

        ang_u   = s_tdata;
        ang_mag = ang_u[31] ? (32'd0 - ang_u) : ang_u;

        mul_a = uw.a_hi ? {16'b0, opa_reg[47:32]} : opa_reg[31:0];
        mul_b = uw.b_hi ? {16'b0, opb_reg[47:32]} : opb_reg[31:0];

        case (pp_sh_reg)
            2'd0:    pp_ext = {16'b0, pp_reg};
            2'd1:    pp_ext = {pp_reg[47:0], 32'b0};
            default: pp_ext = {pp_reg[15:0], 64'b0};
        endcase

        res      = acc_reg[79:32];
        rad_rnd  = acc_reg[62:0] + 63'd524288;
        // Whole-turn estimate from the unrounded radian product; it is low by at most one.
        turn_est = {14'b0, acc_reg[62:44]} * {19'b0, TURN_RECIP_Q24};
        turn_sub = {36'b0, quo_reg} * {8'b0, TWO_PI_Q32};
        rad_red  = (rad_reg >= {8'b0, TWO_PI_Q32}) ? (rad_reg - {8'b0, TWO_PI_Q32})
                                                   : rad_reg;
        // An exact multiple of a whole turn lands on 2*pi, not on zero.
        x_fix   = ((rad_red == 43'd0) && rad_nz_reg) ? TWO_PI_Q32 : rad_red[34:0];
        pairs   = (term_pairs_reg > 6'(MAX_TERM_PAIRS)) ? 6'(MAX_TERM_PAIRS)
                                                        : term_pairs_reg;
        done    = (rc_reg[RC_W-1:1] == pairs);
        sum_abs = sum_reg[47] ? (48'd0 - $unsigned(sum_reg)) : $unsigned(sum_reg);
        sum_rnd = sum_abs + 48'd128;

        busy_next       = busy_reg;
        upc_next        = upc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        term_pairs_next = term_pairs_reg;
        pp_vld_next     = step && uw.mul;
        neg_next        = neg_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        pp_next         = mul_a * mul_b;
        pp_sh_next      = {1'b0, uw.a_hi} + {1'b0, uw.b_hi};
        pp_clr_next     = uw.clr;
        acc_next        = acc_reg;
        rad_next        = rad_reg;
        rad_nz_next     = rad_nz_reg;
        quo_next        = quo_reg;
        x2_next         = x2_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        rc_next         = rc_reg;
        smag_next       = smag_reg;
        fneg_next       = fneg_reg;
        out_data_next   = out_data_reg;
        out_sat_next    = out_sat_reg;

        if (cfg_valid && cfg_ready) begin
            term_pairs_next = cfg_data;
        end

        if (pp_vld_reg) begin
            acc_next = (pp_clr_reg ? 80'd0 : acc_reg) + pp_ext;
        end

        if (s_xfer) begin
            busy_next = 1'b1;
            upc_next  = '0;
            neg_next  = ang_u[31];
            opa_next  = {16'b0, ang_mag};
            opb_next  = {17'b0, DEG_TO_RAD_Q36};
        end

        if (step) begin
            unique case (uw.jc)
                J_NEXT:   upc_next = upc_reg + 1'b1;
                J_ALWAYS: upc_next = uw.target;
                J_DONE:   upc_next = done ? uw.target : upc_reg + 1'b1;
                default:  upc_next = upc_reg + 1'b1;
            endcase

            unique case (uw.act)
                A_NOP: begin
                end
                A_RAD: begin
                    rad_next    = rad_rnd[62:20];
                    rad_nz_next = (rad_rnd[62:20] != 43'd0);
                    quo_next    = turn_est[30:24];
                end
                A_DIV: begin
                    // Takes off the estimated whole turns; the fix step removes the last one.
                    rad_next = rad_reg - turn_sub;
                end
                A_FIX: begin
                    term_next = {13'b0, x_fix};
                    opa_next  = {13'b0, x_fix};
                    opb_next  = {13'b0, x_fix};
                    sum_next  = '0;
                    rc_next   = '0;
                end
                A_WX2: begin
                    x2_next = res;
                end
                A_ADD: begin
                    sum_next = sum_reg + $signed(term_reg);
                    opa_next = term_reg;
                    opb_next = x2_reg;
                end
                A_WP: begin
                    opa_next = res;
                    opb_next = {16'b0, RECIP_ROM[rc_reg[5:0]]};
                end
                A_SUB: begin
                    term_next = res;
                    sum_next  = sum_reg - $signed(res);
                    rc_next   = rc_reg + 1'b1;
                    opa_next  = res;
                    opb_next  = x2_reg;
                end
                A_NEWT: begin
                    term_next = res;
                    rc_next   = rc_reg + 1'b1;
                end
                A_RND: begin
                    smag_next = sum_rnd[47:8];
                    fneg_next = (sum_reg[47] ^ neg_reg) && (sum_reg != 48'sd0);
                end
                A_OUT: begin
                    if (fneg_reg) begin
                        out_sat_next  = (smag_reg > 40'h00_8000_0000);
                        out_data_next = out_sat_next ? 32'h8000_0000
                                                     : (32'd0 - smag_reg[31:0]);
                    end else begin
                        out_sat_next  = (smag_reg > 40'h00_7FFF_FFFF);
                        out_data_next = out_sat_next ? 32'h7FFF_FFFF : smag_reg[31:0];
                    end
                    m_tvalid_next = 1'b1;
                    busy_next     = 1'b0;
                    upc_next      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            upc_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            term_pairs_reg <= TERM_PAIRS_RESET;
            pp_vld_reg     <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            upc_reg        <= upc_next;
            m_tvalid_reg   <= m_tvalid_next;
            term_pairs_reg <= term_pairs_next;
            pp_vld_reg     <= pp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        pp_reg       <= pp_next;
        pp_sh_reg    <= pp_sh_next;
        pp_clr_reg   <= pp_clr_next;
        acc_reg      <= acc_next;
        rad_reg      <= rad_next;
        rad_nz_reg   <= rad_nz_next;
        quo_reg      <= quo_next;
        x2_reg       <= x2_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        rc_reg       <= rc_next;
        smag_reg     <= smag_next;
        fneg_reg     <= fneg_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    // A transfer always starts the program at its first step.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (busy_reg && (upc_reg == '0)))
        else $error("sequencer did not start at step zero after an input transfer");

    // Turn reduction leaves the radian magnitude below two whole turns.
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (upc_reg == UPC_FIX)) |-> (rad_reg < {7'b0, TWO_PI_Q32, 1'b0}))
        else $error("angle reduction left a value of two turns or more");

    // The term counter never runs past the reciprocal table.
    a_rc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (upc_reg >= UPC_CHK)) |-> (rc_reg <= RC_W'(RECIP_DEPTH)))
        else $error("term counter ran past the reciprocal table");

    // A result still waiting holds the sequencer at its output step.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (upc_reg == UPC_OUT) && m_tvalid && !m_tready)
        |=> (busy_reg && (upc_reg == UPC_OUT)))
        else $error("pending result was overwritten");

endmodule

FILE: verif/sine_checker.sv
`timescale 1ns / 100ps
// Checker for the degree-input sine block: predicts every result and compares the transfers.
module sine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] angle_degrees
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,     // [31:0] sine_value
    input  logic [0:0]  m_tuser,     // [0] saturated
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    localparam logic [5:0]  PAIRS_AT_RESET = 6'd8;
    localparam int          PAIRS_LIMIT    = 32;
    localparam logic [63:0] DEG2RAD_Q36    = 64'd1199381129;
    localparam logic [63:0] FULL_TURN_Q32  = 64'h6_487E_D511;
    localparam logic [63:0] ONE_Q32        = 64'h1_0000_0000;
    localparam logic [63:0] RAD_ROUND      = 64'd1 << 19;
    localparam logic [63:0] Q8_24_ROUND    = 64'd128;
    localparam logic [63:0] POS_CLAMP      = 64'h7FFF_FFFF;
    localparam logic [63:0] NEG_CLAMP      = 64'h8000_0000;

    typedef struct {
        logic [31:0] angle;
        logic [31:0] sine_value;
        logic        saturated;
    } sine_t;

    sine_t      expected_sines[$];
    sine_t      oldest;
    logic [5:0] pairs_setting = PAIRS_AT_RESET;
    int         fail_count = 0;

    // floor(a * b / 2^32), exact for the operand sizes that occur here.
    function automatic logic [63:0] q32_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    // t * x^2 / ((k + 1)(k + 2)), the reciprocal truncated to Q32 like a ROM entry.
    function automatic logic [63:0] next_term(logic [63:0] t, logic [63:0] x2, int k);
        logic [63:0] recip;
        recip = ONE_Q32 / 64'((k + 1) * (k + 2));
        return q32_product(q32_product(t, x2), recip);
    endfunction

    function automatic sine_t predict_sine(logic [31:0] angle, logic [5:0] pairs_cfg);
        sine_t              res;
        logic [63:0]        mag, rad, x2, term, smag;
        logic signed [63:0] acc;
        int                 pairs;
        int                 i;
        res.angle     = angle;
        res.saturated = 1'b0;
        mag = angle[31] ? ONE_Q32 - {32'd0, angle} : {32'd0, angle};
        rad = (mag * DEG2RAD_Q36 + RAD_ROUND) >> 20;
        if (rad > FULL_TURN_Q32) begin
            rad = rad % FULL_TURN_Q32;
            // A whole number of turns lands on a full turn, not on zero.
            if (rad == 64'd0) begin
                rad = FULL_TURN_Q32;
            end
        end
        pairs = (pairs_cfg > PAIRS_LIMIT) ? PAIRS_LIMIT : int'(pairs_cfg);
        x2    = q32_product(rad, rad);
        term  = rad;
        acc   = '0;
        for (i = 0; i < pairs; i++) begin
            acc  = acc + $signed(term);
            term = next_term(term, x2, 4 * i + 1);
            acc  = acc - $signed(term);
            term = next_term(term, x2, 4 * i + 3);
        end
        // The sign of the angle is applied after the series on the magnitude.
        if (angle[31]) begin
            acc = -acc;
        end
        if (acc < 0) begin
            smag = ((64'd0 - $unsigned(acc)) + Q8_24_ROUND) >> 8;
            if (smag > NEG_CLAMP) begin
                smag          = NEG_CLAMP;
                res.saturated = 1'b1;
            end
            res.sine_value = 32'(ONE_Q32 - smag);
        end else begin
            smag = ($unsigned(acc) + Q8_24_ROUND) >> 8;
            if (smag > POS_CLAMP) begin
                smag          = POS_CLAMP;
                res.saturated = 1'b1;
            end
            res.sine_value = 32'(smag);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pairs_setting = PAIRS_AT_RESET;
            expected_sines.delete();
        end else begin
            // Results are taken before new angles so that a result is never matched
            // against an angle accepted at the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_sines.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result with nothing expected: sine_value %h saturated %b",
                                 $time, m_tdata, m_tuser[0]);
                    end
                    fail_count++;
                end else begin
                    oldest = expected_sines.pop_front();
                    if (m_tdata !== oldest.sine_value || m_tuser[0] !== oldest.saturated) begin
                        if (fail_count < 10) begin
                            $display("%0t: angle %h: expected sine_value %h saturated %b, got %h %b",
                                     $time, oldest.angle, oldest.sine_value, oldest.saturated,
                                     m_tdata, m_tuser[0]);
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                pairs_setting = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                expected_sines.push_back(predict_sine(s_tdata, pairs_setting));
            end
        end
        mismatches  <= fail_count;
        outstanding <= expected_sines.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the degree-input sine block, with the checker beside it.
module testbench;

    localparam int DEG             = 65536;  // one degree in Q16.16
    localparam int PHASES          = 15;
    localparam int BIG_PAIRS       = 17;
    localparam int BIG_PHASE_ITEMS = 8;
    localparam int PHASE_ITEMS     = 40;
    localparam int MODE_SPAN       = 40;
    localparam int SETTLE_CYCLES   = 800;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic signed [31:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic signed [31:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [5:0]         cfg_data;
    int                 mismatches;
    int                 outstanding;

    int angles_sent  = 0;
    bit sender_calm  = 1'b0;
    int results_seen = 0;
    bit reader_calm  = 1'b0;

    int directed_angles[] = '{
        0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_FFFF, 32'shFFFF_0000,
        30 * DEG, -45 * DEG, 90 * DEG, -90 * DEG, 180 * DEG, -180 * DEG, 270 * DEG,
        360 * DEG - 1, 360 * DEG, -360 * DEG, 360 * DEG + 1, 720 * DEG, -1080 * DEG + 7
    };

    // Zero pairs, the range ends and settings above the pair limit come first.
    int fixed_pairs[] = '{0, 1, 32, 63, 2, 33, 3};

    taylor_sine_degrees u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sine_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int random_angle();
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
            2: return int'($urandom_range(0, 16 * DEG)) - 8 * DEG;
            default: return (int'($urandom_range(0, 16)) - 8) * 90 * DEG
                            + int'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    // Leaves tvalid high after the transfer so that back-to-back angles need not raise it again.
    task automatic send_angle(input int angle);
        int gap;
        if (angles_sent % MODE_SPAN == 0) begin
            sender_calm = ($urandom_range(0, 2) == 0);
        end
        angles_sent++;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_term_pairs(input logic [5:0] pairs);
        wait_for_results();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= pairs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int n;
        int pairs;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_angles[i]) begin
            send_angle(directed_angles[i]);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < fixed_pairs.size()) begin
                pairs = fixed_pairs[ph];
            end else if ($urandom_range(0, 4) == 0) begin
                pairs = $urandom_range(13, 63);
            end else begin
                pairs = $urandom_range(0, 12);
            end
            write_term_pairs(6'(pairs));
            // Long series are slow, so those settings get only a few angles.
            for (n = 0; n < ((pairs >= BIG_PAIRS) ? BIG_PHASE_ITEMS : PHASE_ITEMS); n++) begin
                send_angle(random_angle());
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: each stall counts from the moment a result is offered.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (results_seen % MODE_SPAN == 0) begin
                reader_calm = ($urandom_range(0, 2) == 0);
            end
            results_seen++;
            stall = reader_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
